// ===== design/ecsm_pkg.sv =====
// shared types and constants for the elliptic-curve scalar multiply core
`timescale 1ns / 1ps
package ecsm_pkg;

    localparam int CfgIdxBits = 2;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_PRIME = 2'd0,
        CFG_A     = 2'd1,
        CFG_B     = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_DGO,
        S_DWT,
        S_I1,
        S_I2,
        S_I3,
        S_I4,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_C5,
        S_FIND,
        S_DBL0,
        S_DBL1,
        S_DBL2,
        S_DBL3,
        S_F_INV0,
        S_EU_TEST,
        S_EU_Q,
        S_EU_T,
        S_F_S,
        S_F_X1,
        S_F_X2,
        S_F_X3,
        S_F_X4,
        S_F_X5,
        S_OUT
    } t_state;

endpackage

// ===== design/ecsm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ecsm_div #(
    parameter int N = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*N-1:0] i_dividend,
    input  logic [N-1:0]   i_divisor,
    output logic           o_done,
    output logic [2*N-1:0] o_quo,
    output logic [N-1:0]   o_rem
);
    localparam int CntBits = $clog2(2 * N + 1);

    logic [2*N-1:0]   r_q;
    logic [N-1:0]     r_r;
    logic [N-1:0]     r_dvs;
    logic [CntBits-1:0] r_cnt;
    logic             r_done;
    logic [N:0]       w_trial;
    logic             w_ge;

    assign w_trial = {r_r, r_q[2*N-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CntBits'(2 * N);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[2*N-2:0], w_ge};
            r_r <= w_ge ? N'(w_trial - {1'b0, r_dvs}) : w_trial[N-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

endmodule

// ===== design/ec_scalar_multiply_core.sv =====
// elliptic-curve scalar multiply, left-to-right double-and-add over a small prime field
// sequence: reduction and curve check, then a search down the scalar for its top set bit, then
//   per lower bit a doubling and an optional addition, each one euclid inverse (two divider
//   passes per round) plus three or four mulmods
// throughput: one request at a time, a new one is taken once the result is in the output register
// reset: synchronous active-low, registers come up as prime 23, a 1, b 1; output empty
`timescale 1ns / 1ps
module ec_scalar_multiply_core #(
    parameter int COORD_BITS  = 16,
    parameter int SCALAR_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [SCALAR_BITS-1:0]     i_scalar,
    input  logic [COORD_BITS-1:0]      i_base_x,
    input  logic [COORD_BITS-1:0]      i_base_y,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [COORD_BITS-1:0]      o_result_x,
    output logic [COORD_BITS-1:0]      o_result_y,
    output logic                       o_on_curve,
    output logic                       o_degenerate,
    // register write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ecsm_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]      i_cfg_data
);
    import ecsm_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int NB = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

    // modular add and subtract on operands already below m
    function automatic logic [N-1:0] f_add(input logic [N-1:0] x, input logic [N-1:0] y,
                                           input logic [N-1:0] m);
        logic [N:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[N-1:0];
    endfunction

    function automatic logic [N-1:0] f_sub(input logic [N-1:0] x, input logic [N-1:0] y,
                                           input logic [N-1:0] m);
        logic [N:0] d;
        if (x >= y) begin
            d = {1'b0, x} - {1'b0, y};
        end else begin
            d = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return d[N-1:0];
    endfunction

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // configuration registers, raw as written
    logic [N-1:0] r_p, r_ca, r_cb;

    // datapath
    logic [SCALAR_BITS-1:0] r_k;
    logic [NB-1:0]  r_bit;
    logic [N-1:0]   r_m, r_a, r_b, r_bx, r_by, r_cx, r_cy;
    logic [N-1:0]   r_num, r_den, r_px, r_py, r_qx, r_s, r_t, r_x3, r_dx, r_dy;
    logic [N-1:0]   r_r0, r_r1, r_t0, r_t1;
    logic [N-1:0]   r_opx, r_opy, r_dvs;
    logic [2*N-1:0] r_prod;
    logic           r_add, r_deg, r_onc;

    // result register
    logic           r_ovalid;
    logic [N-1:0]   r_res_x, r_res_y;
    logic           r_res_onc, r_res_deg;

    logic           w_in_acc, w_out_load, w_div_start, w_div_done;
    logic [2*N-1:0] w_quo;
    logic [N-1:0]   w_rem;

    assign w_in_acc    = i_valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign w_div_start = (r_state == S_DGO);

    // shared divider: every mulmod reduction and every euclid quotient goes through it
    ecsm_div #(.N(N)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dvs),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // state, handshake and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_p      <= N'(23);
            r_ca     <= N'(1);
            r_cb     <= N'(1);
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PRIME: r_p  <= i_cfg_data;
                    CFG_A:     r_ca <= i_cfg_data;
                    CFG_B:     r_cb <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // sequencer: arithmetic states hand off to the shared mulmod/divide path and name a return
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_MUL;
                    n_ret   = S_I1;
                end
            end
            S_MUL:  n_state = S_DGO;
            S_DGO:  n_state = S_DWT;
            S_DWT: begin
                if (w_div_done) begin
                    n_state = r_ret;
                end
            end
            S_I1: begin n_state = S_MUL; n_ret = S_I2; end
            S_I2: begin n_state = S_MUL; n_ret = S_I3; end
            S_I3: begin n_state = S_MUL; n_ret = S_I4; end
            S_I4: begin n_state = S_MUL; n_ret = S_C1; end
            S_C1: begin n_state = S_MUL; n_ret = S_C2; end
            S_C2: begin n_state = S_MUL; n_ret = S_C3; end
            S_C3: begin n_state = S_MUL; n_ret = S_C4; end
            S_C4:   n_state = S_C5;
            S_C5:   n_state = S_FIND;
            S_FIND: begin
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end else if (r_k[r_bit]) begin
                    n_state = S_DBL0;
                end
            end
            S_DBL0: begin n_state = S_MUL; n_ret = S_DBL1; end
            S_DBL1:   n_state = S_DBL2;
            S_DBL2:   n_state = S_DBL3;
            S_DBL3:   n_state = S_F_INV0;
            S_F_INV0: n_state = S_EU_TEST;
            S_EU_TEST: begin
                if (r_r1 == '0) begin
                    if (r_r0 == N'(1)) begin
                        n_state = S_MUL;
                        n_ret   = S_F_S;
                    end else begin
                        n_state = S_F_X1;
                    end
                end else begin
                    n_state = S_MUL;
                    n_ret   = S_EU_Q;
                end
            end
            S_EU_Q: begin n_state = S_MUL; n_ret = S_EU_T; end
            S_EU_T:  n_state = S_EU_TEST;
            S_F_S:   n_state = S_F_X1;
            S_F_X1: begin n_state = S_MUL; n_ret = S_F_X2; end
            S_F_X2:  n_state = S_F_X3;
            S_F_X3: begin n_state = S_MUL; n_ret = S_F_X4; end
            S_F_X4:  n_state = S_F_X5;
            S_F_X5: begin
                if (!r_add && r_k[r_bit]) begin
                    n_state = S_F_INV0;
                end else if (r_bit == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DBL0;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // zero modulus behaves as modulus one
                    r_m   <= (r_p == '0) ? N'(1) : r_p;
                    r_dvs <= (r_p == '0) ? N'(1) : r_p;
                    r_k   <= i_scalar;
                    r_cy  <= i_base_y;
                    r_deg <= 1'b0;
                    r_opx <= i_base_x;
                    r_opy <= N'(1);
                end
            end
            S_MUL: r_prod <= (2*N)'(r_opx) * (2*N)'(r_opy);
            S_I1: begin r_bx <= w_rem; r_opx <= r_cy; end
            S_I2: begin r_by <= w_rem; r_opx <= r_ca; end
            S_I3: begin r_a  <= w_rem; r_opx <= r_cb; end
            S_I4: begin
                r_b   <= w_rem;
                r_opx <= r_by;
                r_opy <= r_by;
            end
            // curve check: y^2 against x^3 + a*x + b
            S_C1: begin r_t <= w_rem; r_opx <= r_bx; r_opy <= r_bx; end
            S_C2: begin r_opx <= w_rem; r_opy <= r_bx; end
            S_C3: begin r_num <= w_rem; r_opx <= r_a; r_opy <= r_bx; end
            S_C4: r_num <= f_add(r_num, w_rem, r_m);
            S_C5: begin
                r_onc <= (f_add(r_num, r_b, r_m) == r_t);
                r_cx  <= r_bx;
                r_cy  <= r_by;
                r_bit <= NB'(SCALAR_BITS - 1);
            end
            S_FIND: begin
                if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                end
            end
            // doubling slope 3x^2 + a over 2y
            S_DBL0: begin r_opx <= r_cx; r_opy <= r_cx; end
            S_DBL1: r_t <= f_add(w_rem, w_rem, r_m);
            S_DBL2: r_t <= f_add(r_t, w_rem, r_m);
            S_DBL3: begin
                r_num <= f_add(r_t, r_a, r_m);
                r_den <= f_add(r_cy, r_cy, r_m);
                r_px  <= r_cx;
                r_py  <= r_cy;
                r_qx  <= r_cx;
                r_add <= 1'b0;
            end
            // extended euclid, cofactor kept mod m
            S_F_INV0: begin
                r_r0 <= r_m;
                r_r1 <= r_den;
                r_t0 <= '0;
                r_t1 <= (r_m == N'(1)) ? '0 : N'(1);
            end
            S_EU_TEST: begin
                if (r_r1 == '0) begin
                    if (r_r0 == N'(1)) begin
                        r_opx <= r_num;
                        r_opy <= r_t0;
                        r_dvs <= r_m;
                    end else begin
                        // no inverse: slope forced to zero
                        r_s   <= '0;
                        r_deg <= 1'b1;
                        r_dvs <= r_m;
                    end
                end else begin
                    r_opx <= r_r0;
                    r_opy <= N'(1);
                    r_dvs <= r_r1;
                end
            end
            S_EU_Q: begin
                r_r0  <= r_r1;
                r_r1  <= w_rem;
                r_opx <= w_quo[N-1:0];
                r_opy <= r_t1;
                r_dvs <= r_m;
            end
            S_EU_T: begin
                r_t0 <= r_t1;
                r_t1 <= f_sub(r_t0, w_rem, r_m);
            end
            S_F_S:  r_s <= w_rem;
            S_F_X1: begin r_opx <= r_s; r_opy <= r_s; end
            S_F_X2: r_x3 <= f_sub(f_sub(w_rem, r_px, r_m), r_qx, r_m);
            S_F_X3: begin
                r_opx <= r_s;
                r_opy <= f_sub(r_px, r_x3, r_m);
            end
            S_F_X4: begin
                r_dx <= r_x3;
                r_dy <= f_sub(w_rem, r_py, r_m);
            end
            S_F_X5: begin
                if (!r_add && r_k[r_bit]) begin
                    // chord with the base point, used even when the points coincide
                    r_num <= f_sub(r_by, r_dy, r_m);
                    r_den <= f_sub(r_bx, r_dx, r_m);
                    r_px  <= r_dx;
                    r_py  <= r_dy;
                    r_qx  <= r_bx;
                    r_add <= 1'b1;
                end else begin
                    r_cx <= r_dx;
                    r_cy <= r_dy;
                    if (r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_res_x   <= r_cx;
                    r_res_y   <= r_cy;
                    r_res_onc <= r_onc;
                    r_res_deg <= r_deg;
                end
            end
            default: ;
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_result_x   = r_res_x;
    assign o_result_y   = r_res_y;
    assign o_on_curve   = r_res_onc;
    assign o_degenerate = r_res_deg;
    // curve registers only change while no request is being worked on
    assign o_cfg_ready  = (r_state == S_IDLE);

    // working modulus never zero once a request is in flight
    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_MUL && r_state != S_DGO && r_state != S_DWT
         && r_state != S_I1) |-> (r_m != '0))
        else $error("working modulus is zero");

    // accumulator is reduced while the top scalar bit is sought
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (r_cx < r_m && r_cy < r_m))
        else $error("accumulator not reduced");

    // euclid remainders stay bounded by the modulus
    a_euclid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EU_TEST) |-> (r_r0 <= r_m && r_r1 < r_m))
        else $error("euclid remainder out of range");

endmodule
